@@ src/slu_pkg.sv @@
// Shared types, character codes and classification helpers for the lexer.
package slu_pkg;

  // Character codes recognized by the scanner
  localparam logic [20:0] CH_TAB    = 21'h00009;
  localparam logic [20:0] CH_LF     = 21'h0000A;
  localparam logic [20:0] CH_CR     = 21'h0000D;
  localparam logic [20:0] CH_SPACE  = 21'h00020;
  localparam logic [20:0] CH_STAR   = 21'h0002A;
  localparam logic [20:0] CH_SLASH  = 21'h0002F;
  localparam logic [20:0] CH_DIG_LO = 21'h00030;
  localparam logic [20:0] CH_DIG_HI = 21'h00039;
  localparam logic [20:0] CH_EQ     = 21'h0003D;
  localparam logic [20:0] CH_UP_LO  = 21'h00041;
  localparam logic [20:0] CH_UP_HI  = 21'h0005A;
  localparam logic [20:0] CH_UNDER  = 21'h0005F;
  localparam logic [20:0] CH_LOW_LO = 21'h00061;
  localparam logic [20:0] CH_LOW_HI = 21'h0007A;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_EQ    = 3'd1,
    MODE_SLASH = 3'd2,
    MODE_IDENT = 3'd3,
    MODE_LINEC = 3'd4,
    MODE_BLOCK = 3'd5,
    MODE_STAR  = 3'd6,
    MODE_HALT  = 3'd7
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_ASSIGN = 3'd0,
    KIND_EQUAL  = 3'd1,
    KIND_IDENT  = 3'd2,
    KIND_EOF    = 3'd3,
    KIND_ERROR  = 3'd4
  } token_kind_t;

  typedef struct packed {
    token_kind_t  token_kind;
    logic [23:0]  start_line;
    logic [15:0]  start_column;
    logic [31:0]  start_offset;
    logic [15:0]  token_length;
    logic         last_of_run;
  } result_t;

  // Results of one request, pushed to the output queue together
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  function automatic logic is_space(logic [20:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_start(logic [20:0] c);
    return (c inside {[CH_LOW_LO:CH_LOW_HI], [CH_UP_LO:CH_UP_HI]}) || (c == CH_UNDER);
  endfunction

  function automatic logic is_cont(logic [20:0] c);
    return is_start(c) || (c inside {[CH_DIG_LO:CH_DIG_HI]});
  endfunction

endpackage

@@ src/slu_if.sv @@
// Valid/ready channel interfaces for code points in and tokens out.
interface slu_char_if;
  logic        valid;
  logic        ready;
  logic [20:0] char_code;
  logic        end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

interface slu_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [23:0] start_line;
  logic [15:0] start_column;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, token_kind, start_line, start_column, start_offset,
                  token_length, last_of_run, input ready);
  modport sink   (input valid, token_kind, start_line, start_column, start_offset,
                  token_length, last_of_run, output ready);
endinterface

@@ src/slu_core.sv @@
// Scan state, position counters and per-request token decision.
module slu_core import slu_pkg::*; #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [20:0]  char_code,
  input  logic         end_of_input,
  output result_pair_t pair
);

  typedef struct packed {
    logic [LINE_BITS-1:0]   ln;
    logic [COLUMN_BITS-1:0] co;
    logic [31:0]            of;
  } pos_t;

  localparam pos_t POS_RESET = '{ln: LINE_BITS'(1), co: COLUMN_BITS'(1), of: 32'd0};

  scan_mode_t  mode, mode_next;
  pos_t        pos, pos_next;
  pos_t        tok_pos, tok_pos_next;
  logic [15:0] tok_len, tok_len_next;

  result_t     res [2];
  logic [1:0]  cnt;
  logic        do_start;
  logic        eof;

  // Saturating position advance over one code point
  function automatic pos_t advance(pos_t p, logic [20:0] c);
    pos_t q;
    q = p;
    if (q.of != '1) q.of = q.of + 32'd1;
    if (c == CH_LF) begin
      if (q.ln != '1) q.ln = q.ln + LINE_BITS'(1);
      q.co = COLUMN_BITS'(1);
    end else if (q.co != '1) begin
      q.co = q.co + COLUMN_BITS'(1);
    end
    return q;
  endfunction

  function automatic result_t make_result(token_kind_t k, pos_t p, logic [15:0] len);
    result_t r;
    r.token_kind   = k;
    r.start_line   = 24'(p.ln);
    r.start_column = 16'(p.co);
    r.start_offset = p.of;
    r.token_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Next state and results for the request at the port
  always_comb begin
    mode_next    = mode;
    pos_next     = pos;
    tok_pos_next = tok_pos;
    tok_len_next = tok_len;
    res[0]       = make_result(KIND_EOF, pos, 16'd0);
    res[1]       = make_result(KIND_EOF, pos, 16'd0);
    cnt          = 2'd0;
    do_start     = 1'b0;
    eof          = 1'b1;

    if (end_of_input) begin
      case (mode)
        MODE_EQ: begin
          res[cnt[0]] = make_result(KIND_ASSIGN, tok_pos, tok_len);
          cnt = cnt + 2'd1;
        end
        MODE_IDENT: begin
          res[cnt[0]] = make_result(KIND_IDENT, tok_pos, tok_len);
          cnt = cnt + 2'd1;
        end
        MODE_SLASH: begin
          res[cnt[0]] = make_result(KIND_ERROR, pos, 16'd0);
          cnt = cnt + 2'd1;
          eof = 1'b0;
        end
        MODE_HALT: eof = 1'b0;
        default: ;
      endcase
      if (eof) begin
        res[cnt[0]] = make_result(KIND_EOF, pos, 16'd0);
        cnt = cnt + 2'd1;
      end
      mode_next    = MODE_IDLE;
      pos_next     = POS_RESET;
      tok_pos_next = POS_RESET;
      tok_len_next = 16'd0;
    end else begin
      case (mode)
        MODE_IDLE: do_start = 1'b1;
        MODE_EQ: begin
          if (char_code == CH_EQ) begin
            pos_next     = advance(pos_next, char_code);
            tok_len_next = 16'd2;
            res[cnt[0]]  = make_result(KIND_EQUAL, tok_pos, 16'd2);
            cnt          = cnt + 2'd1;
            mode_next    = MODE_IDLE;
          end else begin
            res[cnt[0]] = make_result(KIND_ASSIGN, tok_pos, tok_len);
            cnt         = cnt + 2'd1;
            do_start    = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_code == CH_SLASH) begin
            pos_next  = advance(pos_next, char_code);
            mode_next = MODE_LINEC;
          end else if (char_code == CH_STAR) begin
            pos_next  = advance(pos_next, char_code);
            mode_next = MODE_BLOCK;
          end else begin
            res[cnt[0]] = make_result(KIND_ERROR, pos, 16'd0);
            cnt         = cnt + 2'd1;
            mode_next   = MODE_HALT;
          end
        end
        MODE_IDENT: begin
          if (is_cont(char_code)) begin
            pos_next = advance(pos_next, char_code);
            if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
          end else begin
            res[cnt[0]] = make_result(KIND_IDENT, tok_pos, tok_len);
            cnt         = cnt + 2'd1;
            do_start    = 1'b1;
          end
        end
        MODE_LINEC: begin
          pos_next = advance(pos_next, char_code);
          if (char_code == CH_LF) mode_next = MODE_IDLE;
        end
        MODE_BLOCK: begin
          pos_next = advance(pos_next, char_code);
          if (char_code == CH_STAR) mode_next = MODE_STAR;
        end
        MODE_STAR: begin
          pos_next = advance(pos_next, char_code);
          if (char_code == CH_SLASH) mode_next = MODE_IDLE;
          else if (char_code != CH_STAR) mode_next = MODE_BLOCK;
        end
        default: ;
      endcase

      // Start a new token from the idle state, or after a token that this code point ends
      if (do_start) begin
        tok_pos_next = pos_next;
        tok_len_next = 16'd1;
        pos_next     = advance(pos_next, char_code);
        if (char_code == CH_EQ) mode_next = MODE_EQ;
        else if (is_space(char_code)) mode_next = MODE_IDLE;
        else if (char_code == CH_SLASH) mode_next = MODE_SLASH;
        else if (is_start(char_code)) mode_next = MODE_IDENT;
        else begin
          res[cnt[0]] = make_result(KIND_ERROR, pos_next, 16'd0);
          cnt         = cnt + 2'd1;
          mode_next   = MODE_HALT;
        end
      end
    end

    // Mark the final result of this request
    if (cnt == 2'd1) res[0].last_of_run = 1'b1;
    if (cnt == 2'd2) res[1].last_of_run = 1'b1;
  end

  assign pair.count  = accept ? cnt : 2'd0;
  assign pair.first  = res[0];
  assign pair.second = res[1];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      pos     <= POS_RESET;
      tok_pos <= POS_RESET;
      tok_len <= 16'd0;
    end else if (accept) begin
      mode    <= mode_next;
      pos     <= pos_next;
      tok_pos <= tok_pos_next;
      tok_len <= tok_len_next;
    end
  end

  // After end of input everything restarts
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> mode == MODE_IDLE && pos == POS_RESET)
    else $error("state not restarted after end of input");

  // Halted scanner stays silent until end of input
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HALT && !end_of_input |-> cnt == 2'd0)
    else $error("result produced while halted");

endmodule

@@ src/slu_queue.sv @@
// Four-entry result queue that takes up to two results per cycle.
module slu_queue import slu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  result_pair_t push,
  output logic         room,
  slu_token_if.source  tokens
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  result_t              entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [PTR_BITS:0]    count;
  logic                 pop;
  result_t              head;

  assign pop  = tokens.valid && tokens.ready;
  assign room = count <= (PTR_BITS + 1)'(QUEUE_DEPTH - 2);
  assign head = entries[rd_ptr];

  // Result storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + PTR_BITS'(1)] <= push.second;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + (PTR_BITS + 1)'(push.count) - (PTR_BITS + 1)'(pop);
    end
  end

  assign tokens.valid        = count != '0;
  assign tokens.token_kind   = head.token_kind;
  assign tokens.start_line   = head.start_line;
  assign tokens.start_column = head.start_column;
  assign tokens.start_offset = head.start_offset;
  assign tokens.token_length = head.token_length;
  assign tokens.last_of_run  = head.last_of_run;

  // A push never lands on a queue without room for a pair
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= (PTR_BITS + 1)'(QUEUE_DEPTH - 2))
    else $error("result queue overflow");

  // Fill level tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd0 && !pop |=> $stable(count))
    else $error("queue level changed without traffic");

endmodule

@@ src/small_language_lexer_unit.sv @@
// Top level of the streaming lexer: scan core plus result queue.
// A token is written into the result queue when the code point that ends it is accepted.
// Throughput: one code point per cycle; a request may yield two tokens, which
// leave one per cycle through the four-entry result queue, and input stalls
// while that queue holds more than two results.
// Reset (rst, synchronous): scan mode idle, line/column 1, offset 0, queue empty.
module small_language_lexer_unit import slu_pkg::*; #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  slu_char_if.sink    chars,
  slu_token_if.source tokens
);

  logic         room;
  logic         accept;
  result_pair_t pair;

  assign chars.ready = room;
  assign accept      = chars.valid && room;

  slu_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (chars.char_code),
    .end_of_input (chars.end_of_input),
    .pair         (pair)
  );

  slu_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (pair),
    .room   (room),
    .tokens (tokens)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the streaming lexer: token prediction against random source text.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import slu_pkg::*;

  localparam int RANDOM_ITEMS = 520;
  localparam int LONG_IDENT   = 300;
  localparam int SINK_HOLD    = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 64;

  localparam logic [20:0] CH_NUL  = 21'h00000;
  localparam logic [20:0] CH_HASH = 21'h00023;
  localparam logic [20:0] CH_MAX  = 21'h10FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slu_char_if  chars_if ();
  slu_token_if tokens_if ();

  small_language_lexer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  initial forever #4 clk = ~clk;

  // Bookkeeping shared by the driver, the receiver and the checker
  result_t     expected_tokens[$];
  logic [20:0] src_text[$];
  int          fail_count    = 0;
  int          sent_items    = 0;
  int          quiet_cycles  = 0;
  int          sink_hold_req = 0;
  bit          src_high      = 1'b0;
  bit          src_steady    = 1'b0;
  bit          sink_steady   = 1'b0;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  scan_mode_t  lex_mode;
  logic [23:0] cur_line;
  logic [15:0] cur_col;
  logic [31:0] cur_off;
  logic [23:0] start_ln;
  logic [15:0] start_col;
  logic [31:0] start_off;
  logic [15:0] run_len;
  result_t     step_tokens[2];
  int          step_count;

  function void lexer_restart();
    lex_mode  = MODE_IDLE;
    cur_line  = 24'd1;
    cur_col   = 16'd1;
    cur_off   = 32'd0;
    start_ln  = 24'd1;
    start_col = 16'd1;
    start_off = 32'd0;
    run_len   = 16'd0;
  endfunction

  function bit blank_char(logic [20:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function bit word_head(logic [20:0] c);
    return (c >= CH_LOW_LO && c <= CH_LOW_HI) || (c >= CH_UP_LO && c <= CH_UP_HI) ||
           c == CH_UNDER;
  endfunction

  function bit word_tail(logic [20:0] c);
    return word_head(c) || (c >= CH_DIG_LO && c <= CH_DIG_HI);
  endfunction

  // Position counters, all saturating
  function void count_char(logic [20:0] c);
    if (cur_off != '1) cur_off++;
    if (c == CH_LF) begin
      if (cur_line != '1) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col != '1) begin
      cur_col++;
    end
  endfunction

  function void add_token(token_kind_t kind, logic [23:0] ln, logic [15:0] col,
                          logic [31:0] off, logic [15:0] len);
    step_tokens[step_count] = {kind, ln, col, off, len, 1'b0};
    step_count++;
  endfunction

  function void add_pending(token_kind_t kind);
    add_token(kind, start_ln, start_col, start_off, run_len);
  endfunction

  // Error sits at the current position: just past a stray character, or just past a slash that opens no comment
  function void flag_error();
    add_token(KIND_ERROR, cur_line, cur_col, cur_off, 16'd0);
    lex_mode = MODE_HALT;
  endfunction

  function void begin_token(logic [20:0] c);
    start_ln  = cur_line;
    start_col = cur_col;
    start_off = cur_off;
    run_len   = 16'd1;
    count_char(c);
    if (c == CH_EQ) lex_mode = MODE_EQ;
    else if (blank_char(c)) lex_mode = MODE_IDLE;
    else if (c == CH_SLASH) lex_mode = MODE_SLASH;
    else if (word_head(c)) lex_mode = MODE_IDENT;
    else flag_error();
  endfunction

  // One accepted request: update state, queue the tokens it yields
  function void lex_step(logic [20:0] c, bit eoi);
    bit with_eof;
    step_count = 0;
    with_eof   = 1'b1;
    if (eoi) begin
      case (lex_mode)
        MODE_EQ:    add_pending(KIND_ASSIGN);
        MODE_IDENT: add_pending(KIND_IDENT);
        MODE_SLASH: begin
          flag_error();
          with_eof = 1'b0;
        end
        MODE_HALT:  with_eof = 1'b0;
        default: ;
      endcase
      if (with_eof) add_token(KIND_EOF, cur_line, cur_col, cur_off, 16'd0);
      lexer_restart();
    end else begin
      case (lex_mode)
        MODE_IDLE: begin_token(c);
        MODE_EQ: begin
          if (c == CH_EQ) begin
            count_char(c);
            run_len = 16'd2;
            add_pending(KIND_EQUAL);
            lex_mode = MODE_IDLE;
          end else begin
            add_pending(KIND_ASSIGN);
            begin_token(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            count_char(c);
            lex_mode = MODE_LINEC;
          end else if (c == CH_STAR) begin
            count_char(c);
            lex_mode = MODE_BLOCK;
          end else begin
            flag_error();
          end
        end
        MODE_IDENT: begin
          if (word_tail(c)) begin
            count_char(c);
            if (run_len != '1) run_len++;
          end else begin
            add_pending(KIND_IDENT);
            begin_token(c);
          end
        end
        MODE_LINEC: begin
          count_char(c);
          if (c == CH_LF) lex_mode = MODE_IDLE;
        end
        MODE_BLOCK: begin
          count_char(c);
          if (c == CH_STAR) lex_mode = MODE_STAR;
        end
        MODE_STAR: begin
          count_char(c);
          if (c == CH_SLASH) lex_mode = MODE_IDLE;
          else if (c != CH_STAR) lex_mode = MODE_BLOCK;
        end
        default: ;
      endcase
    end
    for (int i = 0; i < step_count; i++) begin
      step_tokens[i].last_of_run = (i == step_count - 1);
      expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [20:0] pick_code();
    if ($urandom_range(0, 1) == 0) return 21'($urandom_range(0, 127));
    return 21'($urandom_range(0, CH_MAX));
  endfunction

  function automatic logic [20:0] pick_word_char(bit with_digits);
    int roll;
    roll = $urandom_range(0, with_digits ? 62 : 52);
    if (roll < 26) return 21'(CH_LOW_LO + roll);
    if (roll < 52) return 21'(CH_UP_LO + roll - 26);
    if (roll == 52) return CH_UNDER;
    return 21'(CH_DIG_LO + roll - 53);
  endfunction

  function automatic logic [20:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Characters the language has no use for
  function automatic logic [20:0] pick_stray();
    case ($urandom_range(0, 5))
      0: return 21'(CH_DIG_LO + $urandom_range(0, 9));
      1: return CH_HASH;
      2: return CH_NUL;
      3: return CH_MAX;
      4: return CH_STAR;
      default: return 21'($urandom_range(128, CH_MAX));
    endcase
  endfunction

  // Append one code point to the pending source text
  function void add_src(logic [20:0] c);
    src_text.insert(src_text.size(), c);
  endfunction

  // Append one piece of source text, mostly well formed
  function void add_fragment();
    int          roll;
    logic [20:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      add_src(pick_word_char(1'b0));
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(6, 23) : $urandom_range(0, 5))
        add_src(pick_word_char(1'b1));
    end else if (roll < 42) begin
      add_src(CH_EQ);
    end else if (roll < 50) begin
      add_src(CH_EQ);
      add_src(CH_EQ);
    end else if (roll < 66) begin
      repeat ($urandom_range(1, 3)) add_src(pick_blank());
    end else if (roll < 75) begin
      // line comment with arbitrary code points
      add_src(CH_SLASH);
      add_src(CH_SLASH);
      repeat ($urandom_range(0, 8)) begin
        c = pick_code();
        add_src(c == CH_LF ? CH_SPACE : c);
      end
      add_src(CH_LF);
    end else if (roll < 85) begin
      // block comment, closed by one or more stars and a slash
      add_src(CH_SLASH);
      add_src(CH_STAR);
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 5))
          0: begin
            add_src(CH_STAR);
            add_src(pick_word_char(1'b1));
          end
          1: add_src(CH_LF);
          2: add_src(CH_SLASH);
          3: add_src(pick_code());
          default: add_src(pick_word_char(1'b1));
        endcase
      end
      repeat ($urandom_range(1, 3)) add_src(CH_STAR);
      add_src(CH_SLASH);
    end else if (roll < 91) begin
      add_src(pick_stray());
    end else if (roll < 95) begin
      // slash that opens no comment
      add_src(CH_SLASH);
      case ($urandom_range(0, 2))
        0: add_src(pick_word_char(1'b0));
        1: add_src(pick_blank());
        default: add_src(CH_EQ);
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) add_src(pick_code());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [20:0] c, bit eoi);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      if (src_high) chars_if.valid <= 1'b0;
      src_high = 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid        <= 1'b1;
    chars_if.char_code    <= c;
    chars_if.end_of_input <= eoi;
    src_high = 1'b1;
    do @(posedge clk); while (!chars_if.ready);
    sent_items++;
    lex_step(c, eoi);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_item({13'd0, s[i]}, 1'b0);
  endtask

  // char_code is a don't care alongside end of input
  task automatic send_eoi();
    send_item(pick_code(), 1'b1);
  endtask

  task automatic pause_until_drained();
    if (src_high) chars_if.valid <= 1'b0;
    src_high = 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Token receiver: random stalls, steady stretches, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : sink_driver
    int stall;
    tokens_if.ready = 1'b0;
    forever begin
      if (sink_hold_req > 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end else if (sink_steady) begin
        stall = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        tokens_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tokens_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : token_check
    result_t want;
    if (!rst && tokens_if.valid && tokens_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: token with none expected, kind %0d line %0d column %0d offset %0d",
                 $time, tokens_if.token_kind, tokens_if.start_line,
                 tokens_if.start_column, tokens_if.start_offset);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        compare_field("token_kind", 32'(want.token_kind), 32'(tokens_if.token_kind));
        compare_field("start_line", 32'(want.start_line), 32'(tokens_if.start_line));
        compare_field("start_column", 32'(want.start_column), 32'(tokens_if.start_column));
        compare_field("start_offset", want.start_offset, tokens_if.start_offset);
        compare_field("token_length", 32'(want.token_length), 32'(tokens_if.token_length));
        compare_field("last_of_run", 32'(want.last_of_run), 32'(tokens_if.last_of_run));
      end
    end
  end

  // Watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, nothing moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // identifier ended by equal, identifier ended by an assign left open at end of input
  task automatic test_token_kinds();
    send_string("z_9==A=");
    send_eoi();
  endtask

  // line comment, block comment across a line break closed by a star run, open comment
  task automatic test_comments();
    send_string("//\n/*\n**//*");
    send_eoi();
  endtask

  task automatic test_bad_input();
    // lone slash mid text, then silence up to end of input
    send_string("/a");
    send_eoi();
    // lone slash right at end of input: error and no end token
    send_string("/");
    send_eoi();
    // identifier cut by the top code point, later input ignored
    send_string("x");
    send_item(CH_MAX, 1'b0);
    send_string("=");
    send_eoi();
    // assign cut by code point zero
    send_string("=");
    send_item(CH_NUL, 1'b0);
    send_eoi();
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits until every token is drained
  task automatic test_output_stall();
    src_steady = 1'b1;
    sink_hold_req = SINK_HOLD;
    for (int i = 0; i < 24; i++) begin
      send_item(21'(CH_LOW_LO + (i % 26)), 1'b0);
      send_item(CH_EQ, 1'b0);
    end
    send_item(CH_LOW_LO, 1'b0);
    send_item(CH_HASH, 1'b0);
    send_eoi();
    pause_until_drained();
    src_steady = 1'b0;
  endtask

  // A long identifier on one line, then a comment and a short tail
  task automatic test_long_line();
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    send_item(pick_word_char(1'b0), 1'b0);
    repeat (LONG_IDENT - 1) send_item(pick_word_char(1'b1), 1'b0);
    send_string("=//ab\nq");
    send_eoi();
    pause_until_drained();
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_random_programs();
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      src_text.delete();
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 12)) add_src(pick_code());
      end else begin
        repeat ($urandom_range(2, 12)) add_fragment();
        // sometimes leave a slash or an open comment at the end
        case ($urandom_range(0, 19))
          0: add_src(CH_SLASH);
          1: begin
            add_src(CH_SLASH);
            add_src(CH_STAR);
            add_src(pick_code());
          end
          default: ;
        endcase
      end
      foreach (src_text[i]) send_item(src_text[i], 1'b0);
      send_eoi();
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    chars_if.valid        = 1'b0;
    chars_if.char_code    = '0;
    chars_if.end_of_input = 1'b0;
    lexer_restart();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_token_kinds();
    test_comments();
    test_bad_input();
    test_output_stall();
    test_long_line();
    test_random_programs();

    pause_until_drained();
    sink_steady = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
